>>> src/bts_pkg.sv
`default_nettype none

package bts_pkg;

   // Fixed-point formats of the block.
   localparam int FRAC = 16;
   localparam int CHAN = 16;

   // Restoring divider: dividend magnitude, divisor and side-band widths.
   localparam int DIV_N      = 40;
   localparam int DIV_D      = 39;
   localparam int DIV_SIDE_W = 96;

   // Queue between the front and the back part.
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // Hash constants.
   localparam logic [31:0] HASH_MUL = 32'd60493;
   localparam logic [31:0] HASH_ADD = 32'd19990303;
   localparam logic [31:0] HASH_OFS = 32'd1376312589;

   typedef enum logic [2:0] {
      CSR_COLOR_A,
      CSR_COLOR_B,
      CSR_MORTAR_COLOR,
      CSR_THICKNESS,
      CSR_TINT_BIAS,
      CSR_UNIT_WIDTH,
      CSR_COURSE_HEIGHT,
      CSR_ROW_MODIFIERS
   } csr_index_type;

   typedef struct packed {
      logic [63:0]        color_a;
      logic [63:0]        color_b;
      logic [63:0]        mortar_color;
      logic [16:0]        thickness;
      logic signed [17:0] tint_bias;
      logic [22:0]        unit_width;
      logic [22:0]        course_height;
      logic [63:0]        row_mod;
   } cfg_type;

   // One classified item as it travels from the front to the back part.
   typedef struct packed {
      logic signed [31:0] x;
      logic [31:0]        row;
      logic [22:0]        ins_y;
      logic               sq_hit;
      logic               off_hit;
   } work_type;

endpackage

`default_nettype wire

>>> src/bts_div.sv
`default_nettype none

module bts_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic [bts_pkg::DIV_N-1:0]           dividend,
   input  logic [bts_pkg::DIV_D-1:0]           divisor,
   input  logic [bts_pkg::DIV_SIDE_W-1:0]      side_i,
   output logic                                out_valid,
   output logic [bts_pkg::DIV_N-1:0]           quot,
   output logic [bts_pkg::DIV_D-1:0]           rem,
   output logic [bts_pkg::DIV_SIDE_W-1:0]      side_o
);

   localparam int N = bts_pkg::DIV_N;
   localparam int D = bts_pkg::DIV_D;
   localparam int W = bts_pkg::DIV_SIDE_W;

   logic         vld_ff  [0:N-1];
   logic [N-1:0] num_ff  [0:N-1];
   logic [D-1:0] rem_ff  [0:N-1];
   logic [D-1:0] den_ff  [0:N-1];
   logic [W-1:0] side_ff [0:N-1];

   // One quotient bit per stage; the quotient shifts in where the dividend shifts out.
   for (genvar i = 0; i < N; i++) begin : g_stage
      logic         vld_cur;
      logic [N-1:0] num_cur;
      logic [D-1:0] rem_cur;
      logic [D-1:0] den_cur;
      logic [W-1:0] side_cur;
      logic [D:0]   trial;
      logic [D+1:0] diff;

      if (i == 0) begin : g_head
         assign vld_cur  = in_valid;
         assign num_cur  = dividend;
         assign rem_cur  = '0;
         assign den_cur  = divisor;
         assign side_cur = side_i;
      end else begin : g_body
         assign vld_cur  = vld_ff[i-1];
         assign num_cur  = num_ff[i-1];
         assign rem_cur  = rem_ff[i-1];
         assign den_cur  = den_ff[i-1];
         assign side_cur = side_ff[i-1];
      end

      always_comb begin
         trial = {rem_cur, num_cur[N-1]};
         diff  = {1'b0, trial} - {2'b00, den_cur};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= vld_cur;
         end
         num_ff[i]  <= {num_cur[N-2:0], ~diff[D+1]};
         rem_ff[i]  <= diff[D+1] ? trial[D-1:0] : diff[D-1:0];
         den_ff[i]  <= den_cur;
         side_ff[i] <= side_cur;
      end
   end

   assign out_valid = vld_ff[N-1];
   assign quot      = num_ff[N-1];
   assign rem       = rem_ff[N-1];
   assign side_o    = side_ff[N-1];

endmodule

`default_nettype wire

>>> src/bts_front.sv
`default_nettype none

module bts_front (
   input  logic                     clock,
   input  logic                     reset,
   input  bts_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   input  logic signed [31:0]       coord_x,
   input  logic signed [31:0]       coord_y,
   output logic                     out_valid,
   output bts_pkg::work_type        out_work
);

   localparam int N = bts_pkg::DIV_N;
   localparam int D = bts_pkg::DIV_D;
   localparam int W = bts_pkg::DIV_SIDE_W;

   logic [22:0]        rh_eff;
   logic               y_neg;
   logic [30:0]        y_mag;

   logic               rd_valid;
   logic [N-1:0]       rd_quot;
   logic [D-1:0]       rd_rem;
   logic [W-1:0]       rd_side;

   logic               f1_vld_ff, f1_vld_in;
   logic signed [31:0] f1_x_ff, f1_x_in;
   logic [31:0]        f1_row_ff, f1_row_in;
   logic [22:0]        f1_ins_y_ff, f1_ins_y_in;
   logic [31:0]        f1_mag_ff, f1_mag_in;

   logic               sq_valid;
   logic [D-1:0]       sq_rem;
   logic [W-1:0]       sq_side;
   logic [D-1:0]       off_rem;
   logic [7:0]         off_period;
   logic [7:0]         sq_period;
   logic               periods_on;

   assign rh_eff = (cfg.course_height == 23'd0) ? 23'd1 : cfg.course_height;

   // Floor division of a negative y runs on its one's complement.
   assign y_neg = coord_y[31];
   assign y_mag = y_neg ? ~coord_y[30:0] : coord_y[30:0];

   bts_div u_row_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (in_valid),
      .dividend  ({9'd0, y_mag}),
      .divisor   ({16'd0, rh_eff}),
      .side_i    ({63'd0, y_neg, coord_x}),
      .out_valid (rd_valid),
      .quot      (rd_quot),
      .rem       (rd_rem),
      .side_o    (rd_side)
   );

   always_comb begin
      f1_vld_in = rd_valid;
      f1_x_in   = rd_side[31:0];
      if (rd_side[32]) begin
         f1_row_in   = ~rd_quot[31:0];
         f1_ins_y_in = rh_eff - 23'd1 - rd_rem[22:0];
         f1_mag_in   = rd_quot[31:0] + 32'd1;
      end else begin
         f1_row_in   = rd_quot[31:0];
         f1_ins_y_in = rd_rem[22:0];
         f1_mag_in   = rd_quot[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
      end else begin
         f1_vld_ff <= f1_vld_in;
      end
      f1_x_ff     <= f1_x_in;
      f1_row_ff   <= f1_row_in;
      f1_ins_y_ff <= f1_ins_y_in;
      f1_mag_ff   <= f1_mag_in;
   end

   assign off_period = cfg.row_mod[7:0];
   assign sq_period  = cfg.row_mod[15:8];
   assign periods_on = (off_period != 8'd0) && (sq_period != 8'd0);

   // Divisibility of the row by both periods, checked on its magnitude.
   bts_div u_sq_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f1_vld_ff),
      .dividend  ({8'd0, f1_mag_ff}),
      .divisor   ({31'd0, sq_period}),
      .side_i    ({9'd0, f1_ins_y_ff, f1_row_ff, f1_x_ff}),
      .out_valid (sq_valid),
      .quot      (),
      .rem       (sq_rem),
      .side_o    (sq_side)
   );

   bts_div u_off_mod (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f1_vld_ff),
      .dividend  ({8'd0, f1_mag_ff}),
      .divisor   ({31'd0, off_period}),
      .side_i    ('0),
      .out_valid (),
      .quot      (),
      .rem       (off_rem),
      .side_o    ()
   );

   always_comb begin
      out_valid        = sq_valid;
      out_work.x       = sq_side[31:0];
      out_work.row     = sq_side[63:32];
      out_work.ins_y   = sq_side[86:64];
      out_work.sq_hit  = periods_on && (sq_rem == '0);
      out_work.off_hit = periods_on && (off_rem == '0);
   end

endmodule

`default_nettype wire

>>> src/bts_queue.sv
`default_nettype none

module bts_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bts_pkg::work_type  push_data,
   input  logic               pop,
   output bts_pkg::work_type  pop_data,
   output logic               not_empty,
   output logic               full
);

   localparam int DEPTH = bts_pkg::QUEUE_DEPTH;
   localparam int PW    = bts_pkg::QPTR_W;

   bts_pkg::work_type mem_ff [0:DEPTH-1];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [PW:0]       cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign not_empty = (cnt_ff != '0);
   assign full      = (cnt_ff == (PW+1)'(DEPTH));
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

>>> src/bts_back.sv
`default_nettype none

module bts_back (
   input  logic               clock,
   input  logic               reset,
   input  bts_pkg::cfg_type   cfg,
   input  logic               in_valid,
   input  bts_pkg::work_type  in_work,
   output logic               out_valid,
   output logic [15:0]        color_red,
   output logic [15:0]        color_green,
   output logic [15:0]        color_blue,
   output logic [15:0]        color_alpha,
   output logic               in_mortar
);

   localparam int FRAC = bts_pkg::FRAC;
   localparam int N    = bts_pkg::DIV_N;
   localparam int D    = bts_pkg::DIV_D;
   localparam int W    = bts_pkg::DIV_SIDE_W;
   localparam logic [16:0] ONE  = 17'(1 << FRAC);
   localparam logic [33:0] HALF = 34'(1 << (FRAC - 1));

   typedef struct packed {
      logic signed [31:0] x;
      logic [31:0]        row;
      logic [22:0]        ins_y;
      logic               sq_hit;
      logic               off_hit;
      logic [54:0]        prod;
      logic [38:0]        bw;
      logic [40:0]        sx;
      logic [38:0]        ins_x;
      logic [31:0]        key;
      logic               mortar;
      logic [31:0]        n;
      logic [31:0]        sq;
      logic [31:0]        t;
      logic [30:0]        h;
      logic [16:0]        tint;
      logic [2:0][32:0]   pa;
      logic [2:0][32:0]   pb;
   } bk_type;

   logic [22:0]  bw_eff;
   logic [22:0]  rh_eff;

   bk_type st0_ff, st0_in, st1_ff, st1_in, st2_ff, st2_in, st3_ff, st3_in, st4_ff, st4_in;
   bk_type st5_ff, st5_in, st6_ff, st6_in, st7_ff, st7_in, st8_ff, st8_in;
   bk_type st9_ff, st9_in, st10_ff, st10_in, st11_ff, st11_in;
   logic [11:0]  vld_ff, vld_in;

   logic         sx_neg;
   logic         dv_valid;
   logic [N-1:0] dv_quot;
   logic [D-1:0] dv_rem;
   logic [W-1:0] dv_side;
   logic [15:0]  brick;
   logic [31:0]  hash_sum;
   logic [18:0]  tint_sum;
   logic [33:0]  mix_sum [0:2];

   logic         out_valid_ff, out_valid_in;
   logic [15:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in, alpha_ff, alpha_in;
   logic         mortar_ff, mortar_in;

   assign bw_eff = (cfg.unit_width == 23'd0) ? 23'd1 : cfg.unit_width;
   assign rh_eff = (cfg.course_height == 23'd0) ? 23'd1 : cfg.course_height;

   // Width scaling and offset of the special rows.
   always_comb begin
      st0_in         = '0;
      st0_in.x       = in_work.x;
      st0_in.row     = in_work.row;
      st0_in.ins_y   = in_work.ins_y;
      st0_in.sq_hit  = in_work.sq_hit;
      st0_in.off_hit = in_work.off_hit;

      st1_in      = st0_ff;
      st1_in.prod = 55'(bw_eff) * 55'(cfg.row_mod[63:32]);

      st2_in = st1_ff;
      if (st1_ff.sq_hit) begin
         st2_in.bw = (st1_ff.prod[54:FRAC] == '0) ? 39'd1 : st1_ff.prod[54:FRAC];
      end else begin
         st2_in.bw = 39'(bw_eff);
      end

      st3_in      = st2_ff;
      st3_in.prod = 55'(st2_ff.bw) * 55'(cfg.row_mod[31:16]);

      st4_in    = st3_ff;
      st4_in.sx = {{9{st3_ff.x[31]}}, st3_ff.x}
                + (st3_ff.off_hit ? {2'b00, st3_ff.prod[54:16]} : 41'd0);
   end

   assign sx_neg = st4_ff.sx[40];

   bts_div u_brick_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld_ff[4]),
      .dividend  (sx_neg ? ~st4_ff.sx[39:0] : st4_ff.sx[39:0]),
      .divisor   (st4_ff.bw),
      .side_i    ({1'b0, sx_neg, st4_ff.bw, st4_ff.ins_y, st4_ff.row}),
      .out_valid (dv_valid),
      .quot      (dv_quot),
      .rem       (dv_rem),
      .side_o    (dv_side)
   );

   // Brick position, mortar test, hash, tint and the color products.
   always_comb begin
      brick        = dv_side[94] ? ~dv_quot[15:0] : dv_quot[15:0];
      st5_in       = '0;
      st5_in.row   = dv_side[31:0];
      st5_in.ins_y = dv_side[54:32];
      st5_in.bw    = dv_side[93:55];
      st5_in.ins_x = dv_side[94] ? dv_side[93:55] - 39'd1 - dv_rem : dv_rem;
      st5_in.key   = {dv_side[15:0], brick};

      st6_in        = st5_ff;
      st6_in.mortar = (st5_ff.ins_x < 39'(cfg.thickness))
                   || (st5_ff.ins_y < 23'(cfg.thickness))
                   || (({1'b0, st5_ff.ins_x} + 40'(cfg.thickness)) > {1'b0, st5_ff.bw})
                   || (({1'b0, st5_ff.ins_y} + 24'(cfg.thickness)) > {1'b0, rh_eff});
      st6_in.n      = st5_ff.key ^ {{13{st5_ff.key[31]}}, st5_ff.key[31:13]};

      st7_in    = st6_ff;
      st7_in.sq = st6_ff.n * st6_ff.n;

      st8_in   = st7_ff;
      st8_in.t = st7_ff.sq * bts_pkg::HASH_MUL + bts_pkg::HASH_ADD;

      hash_sum = st8_ff.n * st8_ff.t + bts_pkg::HASH_OFS;
      st9_in   = st8_ff;
      st9_in.h = hash_sum[30:0];

      tint_sum = {3'b000, st9_ff.h[30 -: FRAC]} + {cfg.tint_bias[17], cfg.tint_bias};
      st10_in  = st9_ff;
      if (tint_sum[18]) begin
         st10_in.tint = 17'd0;
      end else if (tint_sum[17:0] > 18'(ONE)) begin
         st10_in.tint = ONE;
      end else begin
         st10_in.tint = tint_sum[16:0];
      end

      st11_in = st10_ff;
      for (int k = 0; k < 3; k++) begin
         st11_in.pa[k] = 33'(cfg.color_a[48 - 16*k +: 16]) * 33'(ONE - st10_ff.tint);
         st11_in.pb[k] = 33'(cfg.color_b[48 - 16*k +: 16]) * 33'(st10_ff.tint);
      end
   end

   // Rounded mix or mortar color into the output register.
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mix_sum[k] = 34'(st11_ff.pa[k]) + 34'(st11_ff.pb[k]) + HALF;
      end
      out_valid_in = vld_ff[11];
      mortar_in    = st11_ff.mortar;
      if (st11_ff.mortar) begin
         red_in   = cfg.mortar_color[63:48];
         green_in = cfg.mortar_color[47:32];
         blue_in  = cfg.mortar_color[31:16];
         alpha_in = cfg.mortar_color[15:0];
      end else begin
         red_in   = mix_sum[0][FRAC +: 16];
         green_in = mix_sum[1][FRAC +: 16];
         blue_in  = mix_sum[2][FRAC +: 16];
         alpha_in = cfg.color_a[15:0];
      end
   end

   always_comb begin
      vld_in        = vld_ff;
      vld_in[0]     = in_valid;
      vld_in[4:1]   = vld_ff[3:0];
      vld_in[5]     = dv_valid;
      vld_in[11:6]  = vld_ff[10:5];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         vld_ff       <= vld_in;
         out_valid_ff <= out_valid_in;
      end
      st0_ff    <= st0_in;
      st1_ff    <= st1_in;
      st2_ff    <= st2_in;
      st3_ff    <= st3_in;
      st4_ff    <= st4_in;
      st5_ff    <= st5_in;
      st6_ff    <= st6_in;
      st7_ff    <= st7_in;
      st8_ff    <= st8_in;
      st9_ff    <= st9_in;
      st10_ff   <= st10_in;
      st11_ff   <= st11_in;
      red_ff    <= red_in;
      green_ff  <= green_in;
      blue_ff   <= blue_in;
      alpha_ff  <= alpha_in;
      mortar_ff <= mortar_in;
   end

   assign out_valid   = out_valid_ff;
   assign color_red   = red_ff;
   assign color_green = green_ff;
   assign color_blue  = blue_ff;
   assign color_alpha = alpha_ff;
   assign in_mortar   = mortar_ff;

endmodule

`default_nettype wire

>>> src/brick_texture_shader.sv
// Procedural brick texture: one Q16.16 coordinate pair in, one RGBA color
// and a mortar flag out.
// Input: an item is taken at a rising edge with start high and busy low.
// Output: each result shows on the rsp_ ports for exactly one cycle with
// rsp_strobe high; the receiver always takes it, so the block never stalls
// on its output side.
// Configuration: csr_valid/csr_ready write the register at csr_index with
// csr_data; csr_ready is always high. Write registers only while no item is
// in flight.
// Path: an item runs through three 40-stage restoring dividers in series
// (row, row period test, brick).
// Throughput: one item per cycle while busy is low, results in item order.
// Reset (synchronous) loads the register defaults and empties every stage.
// busy rises only if the queue between the front and back parts fills,
// which a back part that never stalls does not let happen.
`default_nettype none

module brick_texture_shader (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   output logic               rsp_strobe,
   output logic [15:0]        rsp_color_red,
   output logic [15:0]        rsp_color_green,
   output logic [15:0]        rsp_color_blue,
   output logic [15:0]        rsp_color_alpha,
   output logic               rsp_in_mortar,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   bts_pkg::cfg_type  cfg_ff, cfg_in;
   bts_pkg::work_type fr_work;
   bts_pkg::work_type q_data;
   logic              fr_valid;
   logic              q_not_empty;
   logic              q_full;
   logic              accept;

   assign csr_ready = 1'b1;
   assign busy      = q_full;
   assign accept    = start && !busy;

   // Register file. Narrow registers keep the low bits of the write data.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (bts_pkg::csr_index_type'(csr_index))
            bts_pkg::CSR_COLOR_A:       cfg_in.color_a       = csr_data;
            bts_pkg::CSR_COLOR_B:       cfg_in.color_b       = csr_data;
            bts_pkg::CSR_MORTAR_COLOR:  cfg_in.mortar_color  = csr_data;
            bts_pkg::CSR_THICKNESS:     cfg_in.thickness     = csr_data[16:0];
            bts_pkg::CSR_TINT_BIAS:     cfg_in.tint_bias     = csr_data[17:0];
            bts_pkg::CSR_UNIT_WIDTH:    cfg_in.unit_width    = csr_data[22:0];
            bts_pkg::CSR_COURSE_HEIGHT: cfg_in.course_height = csr_data[22:0];
            bts_pkg::CSR_ROW_MODIFIERS: cfg_in.row_mod       = csr_data;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.color_a       <= 64'd0;
         cfg_ff.color_b       <= 64'd0;
         cfg_ff.mortar_color  <= 64'd65535;
         cfg_ff.thickness     <= 17'd1311;
         cfg_ff.tint_bias     <= 18'sd0;
         cfg_ff.unit_width    <= 23'd32768;
         cfg_ff.course_height <= 23'd16384;
         cfg_ff.row_mod       <= 64'h0001_0000_8000_0000;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The front part finds the row and classifies it against both periods.
   bts_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (accept),
      .coord_x   (req_coord_x),
      .coord_y   (req_coord_y),
      .out_valid (fr_valid),
      .out_work  (fr_work)
   );

   // The back part drains the queue whenever it holds an item.
   bts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (fr_valid),
      .push_data (fr_work),
      .pop       (q_not_empty),
      .pop_data  (q_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // The back part finds the brick, applies the mortar test and shades.
   bts_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (q_not_empty),
      .in_work     (q_data),
      .out_valid   (rsp_strobe),
      .color_red   (rsp_color_red),
      .color_green (rsp_color_green),
      .color_blue  (rsp_color_blue),
      .color_alpha (rsp_color_alpha),
      .in_mortar   (rsp_in_mortar)
   );

endmodule

`default_nettype wire

>>> src/bts_checker.sv
`default_nettype none

module bts_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe
);

   localparam int LATENCY = 135;

   // Every accepted item comes out on rsp_strobe after the pipeline latency.
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LATENCY rsp_strobe)
      else $error("accepted item produced no result");

   // No result without an item accepted at the matching edge.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without accepted item");

   // Reset empties the pipeline.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result right after reset");

   // The back part drains the queue whenever it holds an item, so it never fills.
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("queue filled");

endmodule

bind brick_texture_shader bts_checker u_bts_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe)
);

`default_nettype wire
